FILE: sv/hysteretic_differential_steering_defines.svh
// ---------------------------------------------------------------------------
// hysteretic differential steering assertion macros
// property shorthands used by the checker file of the block
// ---------------------------------------------------------------------------
`ifndef HYSTERETIC_DIFFERENTIAL_STEERING_DEFINES_SVH
`define HYSTERETIC_DIFFERENTIAL_STEERING_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hds assertion failed");

// next-cycle implication, disabled while in reset
`define HDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hds assertion failed");

`endif

FILE: sv/hds_pkg.sv
// ---------------------------------------------------------------------------
// hds_pkg
// shared types, constants and the arctangent table of the steering block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hds_pkg;

  // default values of the top-level parameters
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int SPEED_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // fixed field widths
  localparam int HEAD_W    = 16;
  localparam int SPEED_W   = 17;
  localparam int REG_W     = 15;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  // cordic vector width: 16 bit input scaled by 256, gain and sign headroom
  localparam int CORDIC_W = 27;
  // iteration index for the arctangent table and the shifter
  localparam int STEP_W   = 5;
  // radicand is at most 32 bits, two bits per step
  localparam int SQRT_STEPS = 16;
  localparam int ROOT_W     = 16;
  localparam int REM_W      = 17;

  // register reset values
  localparam logic [REG_W-1:0] HARD_THR_RST  = 15'd16384;
  localparam logic [REG_W-1:0] SOFT_THR_RST  = 15'd12743;
  localparam logic [REG_W-1:0] NO_THR_RST    = 15'd1820;
  localparam logic [REG_W-1:0] MAX_SPEED_RST = 15'd2560;

  typedef enum logic [MODE_W-1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_SOFT     = 2'd1,
    MODE_HARD     = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HARD_THR  = 3'd0,
    REG_SOFT_THR  = 3'd1,
    REG_NO_THR    = 3'd2,
    REG_MAX_SPEED = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ITER,
    ST_MODE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              load;
    logic              sq_x;
    logic              sq_y;
    logic              cordic_en;
    logic              sqrt_en;
    logic [STEP_W-1:0] step;
    logic              mode_upd;
    logic              div_en;
    logic              div_first;
    logic              mul;
    logic              result;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/hds_ctrl.sv
// ---------------------------------------------------------------------------
// hds_ctrl
// sequencer: squares, cordic and root iterations, mode update, divide, output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hds_ctrl #(
  parameter int SPEED_BITS   = hds_pkg::SPEED_BITS_DEF,
  parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output hds_pkg::dp_cmd_t       cmd_o,
  input  hds_pkg::dp_status_t    status_i
);

  localparam int ITER_N = (CORDIC_STEPS > hds_pkg::SQRT_STEPS) ? CORDIC_STEPS
                                                              : hds_pkg::SQRT_STEPS;
  localparam int DIV_N  = SPEED_BITS + 1;
  localparam int MAX_N  = (ITER_N > DIV_N) ? ITER_N : DIV_N;
  localparam int CNT_W  = $clog2(MAX_N + 1);

  hds_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             iter_last;
  logic             div_last;

  assign iter_last = (cnt_q == CNT_W'(ITER_N - 1));
  assign div_last  = (cnt_q == CNT_W'(DIV_N - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hds_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hds_pkg::ST_IDLE: if (in_valid_i) state_d = hds_pkg::ST_SQX;
      hds_pkg::ST_SQX:  state_d = hds_pkg::ST_SQY;
      hds_pkg::ST_SQY:  state_d = hds_pkg::ST_ITER;
      hds_pkg::ST_ITER: if (iter_last) state_d = hds_pkg::ST_MODE;
      hds_pkg::ST_MODE: begin
        state_d = status_i.need_div ? hds_pkg::ST_DIV : hds_pkg::ST_OUT;
      end
      hds_pkg::ST_DIV:  if (div_last) state_d = hds_pkg::ST_MUL;
      hds_pkg::ST_MUL:  state_d = hds_pkg::ST_OUT;
      hds_pkg::ST_OUT:  if (status_i.out_free) state_d = hds_pkg::ST_IDLE;
      default:          state_d = hds_pkg::ST_IDLE;
    endcase
  end

  // step counter restarts on every state change
  always_comb begin
    if (state_d != state_q) begin
      cnt_d = '0;
    end else if (state_q == hds_pkg::ST_ITER || state_q == hds_pkg::ST_DIV) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      hds_pkg::ST_SQX:  cmd_o.sq_x = 1'b1;
      hds_pkg::ST_SQY:  cmd_o.sq_y = 1'b1;
      hds_pkg::ST_ITER: begin
        cmd_o.cordic_en = (cnt_q < CNT_W'(CORDIC_STEPS));
        cmd_o.sqrt_en   = (cnt_q < CNT_W'(hds_pkg::SQRT_STEPS));
        cmd_o.step      = hds_pkg::STEP_W'(cnt_q);
      end
      hds_pkg::ST_MODE: cmd_o.mode_upd = 1'b1;
      hds_pkg::ST_DIV: begin
        cmd_o.div_en    = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
      end
      hds_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      hds_pkg::ST_OUT:  cmd_o.result = status_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/hds_datapath.sv
// ---------------------------------------------------------------------------
// hds_datapath
// cordic angle, integer root, turn mode, soft offset divider and wheel output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hds_datapath #(
  parameter int ANGLE_BITS = hds_pkg::ANGLE_BITS_DEF,
  parameter int SPEED_BITS = hds_pkg::SPEED_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hds_pkg::dp_cmd_t                    cmd_i,
  output hds_pkg::dp_status_t                 status_o,
  input  logic signed [hds_pkg::HEAD_W-1:0]   heading_x_i,
  input  logic signed [hds_pkg::HEAD_W-1:0]   heading_y_i,
  input  logic                                cfg_valid_i,
  input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hds_pkg::REG_W-1:0]           cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [hds_pkg::SPEED_W-1:0]  left_speed_o,
  output logic signed [hds_pkg::SPEED_W-1:0]  right_speed_o,
  output logic [hds_pkg::MODE_W-1:0]          turn_mode_o
);

  localparam int CW      = hds_pkg::CORDIC_W;
  localparam int RW      = hds_pkg::REG_W;
  localparam int SW      = hds_pkg::SPEED_W;
  localparam int QW      = SPEED_BITS + 1;
  localparam int PW      = QW + RW;
  localparam int SH      = ANGLE_BITS - 16;
  localparam int SH_R    = (SH > 0) ? SH : 0;
  localparam int SH_L    = (SH < 0) ? -SH : 0;
  localparam int RND_POS = (SH_R > 0) ? SH_R - 1 : 0;
  localparam logic [ANGLE_BITS:0]   Z_RND = (SH > 0) ? ((ANGLE_BITS+1)'(1) << RND_POS) : '0;
  localparam logic [ANGLE_BITS-1:0] Z_PI  = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [32:0]           T_RND = 33'(1) << (31 - ANGLE_BITS);

  // configuration
  logic [RW-1:0] hard_thr_q, soft_thr_q, no_thr_q, max_speed_q;
  hds_pkg::mode_e mode_q, mode_nx;
  logic           out_valid_q;

  // operands
  logic signed [hds_pkg::HEAD_W-1:0] hx_q, hy_q;
  logic                              zero_q;

  // cordic
  logic signed [CW-1:0]     x_q, y_q, x_nx, y_nx, x_ld, y_ld, x_sh, y_sh, x0, y0;
  logic [ANGLE_BITS-1:0]    z_q, z_nx, t_step;
  logic [32:0]              t_sum, t_shr;
  logic [ANGLE_BITS:0]      z_sum;
  logic [47:0]              z_wide, a16_w;
  logic signed [15:0]       ang;
  logic [15:0]              mag;
  logic                     rot_neg;

  // squares and root
  logic signed [hds_pkg::HEAD_W-1:0] sq_op;
  logic signed [31:0]                sq_prod;
  logic [31:0]                       sq_q;
  logic [hds_pkg::REM_W-1:0]         rem_q, rem_nx;
  logic [hds_pkg::ROOT_W-1:0]        root_q, root_nx;
  logic [hds_pkg::REM_W+1:0]         rem_sh, root_trial;

  // mode, divide, multiply
  logic [15:0]     mag_q;
  logic [RW-1:0]   base_q, base;
  logic            ang_pos_q;
  logic [RW-1:0]   r_q, r_nx, off_q;
  logic [QW-1:0]   q_q;
  logic            div_bit, div_ge;
  logic [RW:0]     div_trial, div_diff;
  logic [PW-1:0]   prod_bq;

  // result
  logic signed [SW-1:0] base_s, off_s, max_s, slow, fast;
  logic signed [SW-1:0] left_q, right_q;
  logic [hds_pkg::MODE_W-1:0] turn_q;

  // ---------------- cordic ----------------
  always_comb begin
    x0   = CW'(heading_x_i) <<< 8;
    y0   = CW'(heading_y_i) <<< 8;
    x_ld = heading_x_i[15] ? -x0 : x0;
    y_ld = heading_x_i[15] ? -y0 : y0;
  end

  assign t_sum  = {1'b0, hds_pkg::atan_turn(cmd_i.step)} + T_RND;
  assign t_shr  = t_sum >> (32 - ANGLE_BITS);
  assign t_step = t_shr[ANGLE_BITS-1:0];

  assign x_sh    = x_q >>> cmd_i.step;
  assign y_sh    = y_q >>> cmd_i.step;
  assign rot_neg = !y_q[CW-1] && (y_q != '0);

  always_comb begin
    if (rot_neg) begin
      x_nx = x_q + y_sh;
      y_nx = y_q - x_sh;
      z_nx = z_q + t_step;
    end else begin
      x_nx = x_q - y_sh;
      y_nx = y_q + x_sh;
      z_nx = z_q - t_step;
    end
  end

  // bring the accumulator to 16 bits per turn, round to nearest
  assign z_sum  = {1'b0, z_q} + Z_RND;
  assign z_wide = 48'(z_sum);
  assign a16_w  = (z_wide >> SH_R) << SH_L;
  assign ang    = zero_q ? '0 : $signed(a16_w[15:0]);
  assign mag    = ang[15] ? 16'(-ang) : 16'(ang);

  // ---------------- squares and root ----------------
  assign sq_op   = cmd_i.sq_y ? hy_q : hx_q;
  assign sq_prod = sq_op * sq_op;

  always_comb begin
    rem_sh     = {rem_q, sq_q[31:30]};
    root_trial = {root_q, 2'b01};
    if (rem_sh >= root_trial) begin
      rem_nx  = hds_pkg::REM_W'(rem_sh - root_trial);
      root_nx = {root_q[hds_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nx  = hds_pkg::REM_W'(rem_sh);
      root_nx = {root_q[hds_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  assign base = (root_q < {1'b0, max_speed_q}) ? root_q[RW-1:0] : max_speed_q;

  // ---------------- turn mode with hysteresis ----------------
  always_comb begin
    mode_nx = mode_q;
    if (mode_nx == hds_pkg::MODE_HARD && mag <= {1'b0, soft_thr_q}) begin
      mode_nx = hds_pkg::MODE_SOFT;
    end
    if (mode_nx == hds_pkg::MODE_SOFT) begin
      if (mag > {1'b0, hard_thr_q}) begin
        mode_nx = hds_pkg::MODE_HARD;
      end else if (mag <= {1'b0, no_thr_q}) begin
        mode_nx = hds_pkg::MODE_STRAIGHT;
      end
    end
    if (mode_nx == hds_pkg::MODE_STRAIGHT) begin
      if (mag > {1'b0, hard_thr_q}) begin
        mode_nx = hds_pkg::MODE_HARD;
      end else if (mag > {1'b0, no_thr_q}) begin
        mode_nx = hds_pkg::MODE_SOFT;
      end
    end
  end

  // ---------------- soft offset divide ----------------
  // soft mode implies mag <= hard threshold, so the quotient has SPEED_BITS+1 bits
  assign div_bit   = cmd_i.div_first ? mag_q[0] : 1'b0;
  assign div_trial = {r_q, div_bit};
  assign div_ge    = (div_trial >= {1'b0, hard_thr_q});
  assign div_diff  = div_trial - {1'b0, hard_thr_q};
  assign r_nx      = div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
  assign prod_bq   = PW'(base_q) * PW'(q_q);

  // ---------------- wheel speeds ----------------
  always_comb begin
    base_s = $signed({2'b00, base_q});
    off_s  = $signed({2'b00, off_q});
    max_s  = $signed({2'b00, max_speed_q});
    unique case (mode_q)
      hds_pkg::MODE_SOFT: begin
        slow = base_s - off_s;
        fast = base_s + off_s;
      end
      hds_pkg::MODE_HARD: begin
        slow = -max_s;
        fast = max_s;
      end
      default: begin
        slow = base_s;
        fast = base_s;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_thr_q  <= hds_pkg::HARD_THR_RST;
      soft_thr_q  <= hds_pkg::SOFT_THR_RST;
      no_thr_q    <= hds_pkg::NO_THR_RST;
      max_speed_q <= hds_pkg::MAX_SPEED_RST;
      mode_q      <= hds_pkg::MODE_STRAIGHT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_i)
          hds_pkg::REG_HARD_THR:  hard_thr_q  <= cfg_data_i;
          hds_pkg::REG_SOFT_THR:  soft_thr_q  <= cfg_data_i;
          hds_pkg::REG_NO_THR:    no_thr_q    <= cfg_data_i;
          hds_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mode_upd) begin
        mode_q <= mode_nx;
      end
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hx_q   <= heading_x_i;
      hy_q   <= heading_y_i;
      zero_q <= (heading_x_i == '0) && (heading_y_i == '0);
      x_q    <= x_ld;
      y_q    <= y_ld;
      z_q    <= heading_x_i[15] ? Z_PI : '0;
    end else if (cmd_i.cordic_en) begin
      x_q <= x_nx;
      y_q <= y_nx;
      z_q <= z_nx;
    end

    if (cmd_i.sq_x) begin
      sq_q   <= 32'(sq_prod);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_y) begin
      sq_q <= sq_q + 32'(sq_prod);
    end else if (cmd_i.sqrt_en) begin
      sq_q   <= sq_q << 2;
      rem_q  <= rem_nx;
      root_q <= root_nx;
    end

    if (cmd_i.mode_upd) begin
      mag_q     <= mag;
      base_q    <= base;
      ang_pos_q <= !ang[15] && (ang != '0);
      r_q       <= mag[RW:1];
      q_q       <= '0;
      off_q     <= '0;
    end else if (cmd_i.div_en) begin
      r_q <= r_nx;
      q_q <= {q_q[QW-2:0], div_ge};
    end else if (cmd_i.mul) begin
      off_q <= prod_bq[SPEED_BITS+RW-1:SPEED_BITS];
    end

    if (cmd_i.result) begin
      left_q  <= ang_pos_q ? slow : fast;
      right_q <= ang_pos_q ? fast : slow;
      turn_q  <= mode_q;
    end
  end

  assign status_o.need_div = (mode_nx == hds_pkg::MODE_SOFT) && (hard_thr_q != '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign turn_mode_o   = turn_q;

endmodule

FILE: sv/hysteretic_differential_steering.sv
// ---------------------------------------------------------------------------
// hysteretic_differential_steering
// heading vector to left/right wheel speeds with a hysteretic turn mode
// ---------------------------------------------------------------------------
// usage:
//   input beat (in_valid_i/in_ready_o): signed Q8.8 heading_x_i, heading_y_i
//   output beat (out_valid_o/out_ready_i): left/right speed and turn mode
//   config beat (cfg_valid_i/cfg_ready_o): cfg_idx_i 0 hard threshold,
//   1 soft threshold, 2 no-turn threshold, 3 max speed; other indexes ignored;
//   write only while no item is in flight
// timing:
//   one item at a time; the sequencer runs the two squares, then the shared
//   cordic and root iterations, the mode update and the output; in soft turn
//   with a nonzero hard threshold a serial divide and multiply come between
//   the mode update and the output
//   the next beat can be taken in the cycle after the result is registered
// reset: thresholds and max speed return to defaults, mode to straight
// stall: a result waits in the output register; a new beat is still taken
//   and worked on, and its result waits until that register is free
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hysteretic_differential_steering #(
  parameter int ANGLE_BITS   = hds_pkg::ANGLE_BITS_DEF,
  parameter int SPEED_BITS   = hds_pkg::SPEED_BITS_DEF,
  parameter int CORDIC_STEPS = hds_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [hds_pkg::HEAD_W-1:0]   heading_x_i,
  input  logic signed [hds_pkg::HEAD_W-1:0]   heading_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hds_pkg::SPEED_W-1:0]  left_speed_o,
  output logic signed [hds_pkg::SPEED_W-1:0]  right_speed_o,
  output logic [hds_pkg::MODE_W-1:0]          turn_mode_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hds_pkg::REG_W-1:0]           cfg_data_i
);

  hds_pkg::dp_cmd_t    cmd;
  hds_pkg::dp_status_t status;

  // registers accept a write on any cycle
  assign cfg_ready_o = 1'b1;

  hds_ctrl #(
    .SPEED_BITS   (SPEED_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  hds_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .heading_x_i   (heading_x_i),
    .heading_y_i   (heading_y_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .turn_mode_o   (turn_mode_o)
  );

endmodule

FILE: sv/hds_checker.sv
// ---------------------------------------------------------------------------
// hds_checker
// port-level properties of the steering block, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hysteretic_differential_steering_defines.svh"

module hds_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [hds_pkg::SPEED_W-1:0]  left_speed_o,
  input logic signed [hds_pkg::SPEED_W-1:0]  right_speed_o,
  input logic [hds_pkg::MODE_W-1:0]          turn_mode_o
);

  // a stalled result beat holds
  `HDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(left_speed_o) && $stable(right_speed_o) && $stable(turn_mode_o))

  // hard turn spins in place
  `HDS_ASSERT_IMPL(a_hard_spin, clk_i, rst_ni, out_valid_o && (turn_mode_o == hds_pkg::MODE_HARD), hds_pkg::SPEED_W'(left_speed_o + right_speed_o) == '0)

  // straight driving gives both wheels the same speed
  `HDS_ASSERT_IMPL(a_straight_eq, clk_i, rst_ni, out_valid_o && (turn_mode_o == hds_pkg::MODE_STRAIGHT), left_speed_o == right_speed_o)

  // one item at a time: busy right after an input beat
  `HDS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind hysteretic_differential_steering hds_checker u_hds_checker (.*);

FILE: dv/tb_hysteretic_differential_steering.sv
// ---------------------------------------------------------------------------
// tb_hysteretic_differential_steering
// drives heading beats through the steering block and checks every wheel
// command against an in-bench cordic, integer root and hysteresis predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hysteretic_differential_steering;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic signed [hds_pkg::HEAD_W-1:0] x;
    logic signed [hds_pkg::HEAD_W-1:0] y;
  } heading_t;

  typedef struct packed {
    logic [hds_pkg::SPEED_W-1:0] left;
    logic [hds_pkg::SPEED_W-1:0] right;
    hds_pkg::mode_e              mode;
  } wheel_cmd_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic signed [hds_pkg::HEAD_W-1:0]   heading_x_i = '0;
  logic signed [hds_pkg::HEAD_W-1:0]   heading_y_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [hds_pkg::SPEED_W-1:0]  left_speed_o;
  logic signed [hds_pkg::SPEED_W-1:0]  right_speed_o;
  logic [hds_pkg::MODE_W-1:0]          turn_mode_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_idx_i;
  logic [hds_pkg::REG_W-1:0]           cfg_data_i;

  // predictor copy of the registers and the kept mode
  logic [hds_pkg::REG_W-1:0] hard_thr  = hds_pkg::HARD_THR_RST;
  logic [hds_pkg::REG_W-1:0] soft_thr  = hds_pkg::SOFT_THR_RST;
  logic [hds_pkg::REG_W-1:0] none_thr  = hds_pkg::NO_THR_RST;
  logic [hds_pkg::REG_W-1:0] speed_cap = hds_pkg::MAX_SPEED_RST;
  hds_pkg::mode_e            turn_state = hds_pkg::MODE_STRAIGHT;

  heading_t   heading_q[$];
  wheel_cmd_t wheel_cmd_q[$];

  int   send_gap_pct = 0;
  int   ready_stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   err_cnt = 0;
  logic in_taken = 1'b0;
  real  sweep_deg = 0.0;

  wire in_fire  = in_valid_i && in_ready_o;
  wire out_fire = out_valid_o && out_ready_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  hysteretic_differential_steering dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .heading_x_i   (heading_x_i),
    .heading_y_i   (heading_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .turn_mode_o   (turn_mode_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // atan(2^-i), 65536 per turn, rounded to nearest
  function automatic logic [15:0] atan_bam(input int idx);
    case (idx)
      0:       return 16'd8192;
      1:       return 16'd4836;
      2:       return 16'd2555;
      3:       return 16'd1297;
      4:       return 16'd651;
      5:       return 16'd326;
      6:       return 16'd163;
      7:       return 16'd81;
      8:       return 16'd41;
      9:       return 16'd20;
      10:      return 16'd10;
      11:      return 16'd5;
      12:      return 16'd3;
      13:      return 16'd1;
      14:      return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

  // vectoring cordic; pi comes out as -32768
  function automatic logic signed [15:0] heading_bam(input logic signed [15:0] hx,
                                                     input logic signed [15:0] hy);
    longint px, py, nx, ny;
    logic signed [15:0] acc;
    int i;
    if (hx == 0 && hy == 0) return '0;
    px = hx;
    py = hy;
    px = px * 256;
    py = py * 256;
    acc = '0;
    if (px < 0) begin
      px = -px;
      py = -py;
      acc = {1'b1, 15'd0};
    end
    for (i = 0; i < 16; i++) begin
      if (py > 0) begin
        nx = px + (py >>> i);
        ny = py - (px >>> i);
        acc = acc + atan_bam(i);
      end else begin
        nx = px - (py >>> i);
        ny = py + (px >>> i);
        acc = acc - atan_bam(i);
      end
      px = nx;
      py = ny;
    end
    return acc;
  endfunction

  function automatic longint floor_root(input longint v);
    longint r, b;
    r = 0;
    b = 1;
    b = b << 32;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // updates the kept mode and returns the wheel command of one heading
  function automatic wheel_cmd_t wheel_command(input logic signed [15:0] hx,
                                               input logic signed [15:0] hy);
    logic signed [15:0] ang;
    longint mag, sx, sy, len, cap, base, q, off, slow, fast, lft, rgt;
    longint t_hard, t_soft, t_none;
    wheel_cmd_t c;
    ang = heading_bam(hx, hy);
    mag = ang;
    if (mag < 0) mag = -mag;
    sx = hx;
    sy = hy;
    cap = speed_cap;
    t_hard = hard_thr;
    t_soft = soft_thr;
    t_none = none_thr;
    len = floor_root(sx * sx + sy * sy);
    base = (len < cap) ? len : cap;

    // hard, then soft, then straight, all within one beat
    if (turn_state == hds_pkg::MODE_HARD && mag <= t_soft) turn_state = hds_pkg::MODE_SOFT;
    if (turn_state == hds_pkg::MODE_SOFT) begin
      if (mag > t_hard) turn_state = hds_pkg::MODE_HARD;
      else if (mag <= t_none) turn_state = hds_pkg::MODE_STRAIGHT;
    end
    if (turn_state == hds_pkg::MODE_STRAIGHT) begin
      if (mag > t_hard) turn_state = hds_pkg::MODE_HARD;
      else if (mag > t_none) turn_state = hds_pkg::MODE_SOFT;
    end

    case (turn_state)
      hds_pkg::MODE_SOFT: begin
        off = 0;
        if (t_hard != 0) begin
          q = (mag << hds_pkg::SPEED_BITS_DEF) / t_hard;
          off = (base * q) >> hds_pkg::SPEED_BITS_DEF;
        end
        slow = base - off;
        fast = base + off;
      end
      hds_pkg::MODE_HARD: begin
        slow = -cap;
        fast = cap;
      end
      default: begin
        slow = base;
        fast = base;
      end
    endcase

    // positive angle: slower wheel on the left
    if (ang > 0) begin
      lft = slow;
      rgt = fast;
    end else begin
      lft = fast;
      rgt = slow;
    end
    c.left = lft[hds_pkg::SPEED_W-1:0];
    c.right = rgt[hds_pkg::SPEED_W-1:0];
    c.mode = turn_state;
    return c;
  endfunction

  // driver: a beat is held until taken
  always @(negedge clk_i) begin
    heading_t h;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (heading_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        h = heading_q.pop_front();
        in_valid_i <= 1'b1;
        heading_x_i <= h.x;
        heading_y_i <= h.y;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with random stalls and the occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    wheel_cmd_t want;
    in_taken <= in_fire;
    if (cfg_fire) begin
      case (cfg_idx_i)
        hds_pkg::REG_HARD_THR:  hard_thr = cfg_data_i;
        hds_pkg::REG_SOFT_THR:  soft_thr = cfg_data_i;
        hds_pkg::REG_NO_THR:    none_thr = cfg_data_i;
        hds_pkg::REG_MAX_SPEED: speed_cap = cfg_data_i;
        default:                ;
      endcase
    end
    if (in_fire) wheel_cmd_q.push_back(wheel_command(heading_x_i, heading_y_i));
    if (out_fire) begin
      if (wheel_cmd_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, left %0d right %0d mode %0d",
                 $time, left_speed_o, right_speed_o, turn_mode_o);
      end else begin
        want = wheel_cmd_q.pop_front();
        if (left_speed_o !== want.left) begin
          err_cnt++;
          $display("%0t: left_speed expected %0d got %0d",
                   $time, $signed(want.left), left_speed_o);
        end
        if (right_speed_o !== want.right) begin
          err_cnt++;
          $display("%0t: right_speed expected %0d got %0d",
                   $time, $signed(want.right), right_speed_o);
        end
        if (turn_mode_o !== want.mode) begin
          err_cnt++;
          $display("%0t: turn_mode expected %0d got %0d", $time, want.mode, turn_mode_o);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [hds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hds_pkg::REG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_limits(input int hard, input int soft_lim, input int none, input int cap);
    write_reg(hds_pkg::REG_HARD_THR, (hds_pkg::REG_W)'(hard));
    write_reg(hds_pkg::REG_SOFT_THR, (hds_pkg::REG_W)'(soft_lim));
    write_reg(hds_pkg::REG_NO_THR, (hds_pkg::REG_W)'(none));
    write_reg(hds_pkg::REG_MAX_SPEED, (hds_pkg::REG_W)'(cap));
  endtask

  task automatic write_sorted_limits();
    int none, soft_lim;
    none = $urandom_range(8000);
    soft_lim = $urandom_range(20000, none);
    write_limits($urandom_range(32767, soft_lim), soft_lim, none, $urandom_range(32767));
  endtask

  task automatic add_heading(input int x, input int y);
    heading_t h;
    h.x = (hds_pkg::HEAD_W)'(x);
    h.y = (hds_pkg::HEAD_W)'(y);
    heading_q.push_back(h);
  endtask

  // mostly slow sweeps of the heading angle, so the mode walks through its
  // hysteresis band, with full-range and near-zero noise mixed in
  task automatic queue_random(input int n);
    int pick, len, step, vx, vy;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        step = $urandom_range(60);
        sweep_deg = sweep_deg + step - 30;
        if ($urandom_range(9) == 0) sweep_deg = $urandom_range(359);
        len = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(4000);
        vx = $rtoi(len * $cos(sweep_deg * 3.14159265358979 / 180.0));
        vy = $rtoi(len * $sin(sweep_deg * 3.14159265358979 / 180.0));
      end else if (pick < 80) begin
        vx = $urandom;
        vy = $urandom;
      end else begin
        vx = $urandom_range(600);
        vy = $urandom_range(600);
        vx = vx - 300;
        vy = vy - 300;
      end
      add_heading(vx, vy);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i); while (heading_q.size() != 0 || in_valid_i || wheel_cmd_q.size() != 0);
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input bit hold, input int n);
    send_gap_pct = gap_pct;
    ready_stall_pct = stall_pct;
    if (hold) hold_req++;
    queue_random(n);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_idx_i = hds_pkg::REG_HARD_THR;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and the zero vector
    add_heading(0, 0);
    add_heading(32767, 0);
    add_heading(-32768, 0);
    add_heading(0, 32767);
    add_heading(0, -32768);
    add_heading(32767, 32767);
    add_heading(-32768, -32768);
    add_heading(-32768, 32767);
    add_heading(-1, -1);
    add_heading(1, 0);
    // 5, 30, 100, 80, 60, 5 degrees: straight, soft, hard, stay hard, soft, straight
    add_heading(1000, 87);
    add_heading(866, 500);
    add_heading(-174, 985);
    add_heading(174, 985);
    add_heading(500, 866);
    add_heading(1000, 87);
    // mirrored side swaps the wheels
    add_heading(866, -500);
    add_heading(-174, -985);
    add_heading(174, -985);
    add_heading(500, -866);
    add_heading(20000, -3000);
    add_heading(20000, 12000);
    add_heading(-1000, 0);
    drain();

    run_phase(0, 0, 1'b0, 200);
    write_sorted_limits();
    run_phase(61, 0, 1'b0, 200);
    write_limits(32767, 32767, 32767, 32767);
    run_phase(0, 61, 1'b0, 200);
    write_limits(0, 0, 0, 0);
    run_phase(13, 13, 1'b0, 200);
    write_limits(0, $urandom_range(32767), $urandom_range(32767), $urandom_range(32767));
    run_phase(0, 0, 1'b1, 200);
    write_limits($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                 $urandom_range(32767));
    run_phase(61, 0, 1'b0, 200);
    // writes to unused indexes must leave the registers alone
    write_reg((hds_pkg::CFG_IDX_W)'($urandom_range(7, 4)), (hds_pkg::REG_W)'($urandom));
    write_limits(hds_pkg::HARD_THR_RST, hds_pkg::SOFT_THR_RST, hds_pkg::NO_THR_RST,
                 hds_pkg::MAX_SPEED_RST);
    write_reg((hds_pkg::CFG_IDX_W)'($urandom_range(7, 4)), (hds_pkg::REG_W)'($urandom));
    run_phase(13, 13, 1'b1, 200);
    write_sorted_limits();
    run_phase(0, 61, 1'b0, 200);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
